### design/asrf_pkg.sv
// Shared types and constants of the ADC spike rejection filter.
// Used by asrf_cfg_regs and adc_spike_rejection_filter_unit; no dependencies.
`default_nettype none

package asrf_pkg;

    localparam int SAMPLE_W  = 13;
    localparam int WINDOW_W  = 12;
    localparam int LIMIT_W   = 7;
    localparam int RUN_W     = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 12'd5;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 7'd5;

    typedef enum logic [0:0] {
        REG_WINDOW       = 1'b0,
        REG_REJECT_LIMIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        logic [LIMIT_W-1:0]  reject_limit;
    } cfg_t;

endpackage

`default_nettype wire

### design/asrf_cfg_regs.sv
// APB register file holding the filter window and the reject limit.
// Depends on asrf_pkg.
`default_nettype none

module asrf_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [asrf_pkg::APB_AW-1:0] paddr,
    input  wire logic [asrf_pkg::APB_DW-1:0] pwdata,
    output logic      [asrf_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output asrf_pkg::cfg_t                  cfg
);

    asrf_pkg::cfg_t   cfg_reg;
    asrf_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = asrf_pkg::reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window       <= asrf_pkg::WINDOW_RST;
            cfg_reg.reject_limit <= asrf_pkg::LIMIT_RST;
        end else if (wr_en) begin
            case (idx)
                asrf_pkg::REG_WINDOW: begin
                    cfg_reg.window <= pwdata[asrf_pkg::WINDOW_W-1:0];
                end
                asrf_pkg::REG_REJECT_LIMIT: begin
                    cfg_reg.reject_limit <= pwdata[asrf_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            asrf_pkg::REG_WINDOW: begin
                prdata = {{(asrf_pkg::APB_DW-asrf_pkg::WINDOW_W){1'b0}}, cfg_reg.window};
            end
            asrf_pkg::REG_REJECT_LIMIT: begin
                prdata = {{(asrf_pkg::APB_DW-asrf_pkg::LIMIT_W){1'b0}}, cfg_reg.reject_limit};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/adc_spike_rejection_filter_unit.sv
// Stages: s1 register, then output register; last value and run update in one step.
// Throughput: one word per cycle while m_tready does not stall the output.
// Reset (aresetn low, synchronous): pipeline empties, last value and run clear,
// window and reject limit return to 5.
// Depends on asrf_pkg and asrf_cfg_regs.
`default_nettype none

module adc_spike_rejection_filter_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [asrf_pkg::S_TDATA_W-1:0] s_tdata,  // [12:0] raw_sample
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [asrf_pkg::M_TDATA_W-1:0] m_tdata,  // [12:0] filtered_value
    output logic                               m_tuser,  // [0] rejected
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [asrf_pkg::APB_AW-1:0]    paddr,
    input  wire logic [asrf_pkg::APB_DW-1:0]    pwdata,
    output logic      [asrf_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    asrf_pkg::cfg_t cfg;

    asrf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                                s1_valid_reg;
    logic signed [asrf_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                                m_valid_reg;
    logic signed [asrf_pkg::SAMPLE_W-1:0] m_value_reg;
    logic                                m_rej_reg;
    logic signed [asrf_pkg::SAMPLE_W-1:0] last_reg;
    logic signed [asrf_pkg::SAMPLE_W-1:0] last_next;
    logic signed [asrf_pkg::RUN_W-1:0]    run_reg;
    logic signed [asrf_pkg::RUN_W-1:0]    run_next;

    logic                                advance;
    logic                                fire;
    logic signed [asrf_pkg::SAMPLE_W:0]   s_w;
    logic signed [asrf_pkg::SAMPLE_W:0]   last_w;
    logic signed [asrf_pkg::SAMPLE_W:0]   win_w;
    logic signed [asrf_pkg::SAMPLE_W:0]   lo_bound;
    logic signed [asrf_pkg::SAMPLE_W:0]   hi_bound;
    logic signed [asrf_pkg::RUN_W-1:0]    lim_w;
    logic signed [asrf_pkg::RUN_W-1:0]    neg_lim;
    logic                                go_low;
    logic                                go_high;
    logic                                rej_next;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign fire     = s1_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_sample_reg <= s_tdata[asrf_pkg::SAMPLE_W-1:0];
        end
    end

    assign s_w      = {s1_sample_reg[asrf_pkg::SAMPLE_W-1], s1_sample_reg};
    assign last_w   = {last_reg[asrf_pkg::SAMPLE_W-1], last_reg};
    assign win_w    = {2'b00, cfg.window};
    assign lo_bound = last_w - win_w;
    assign hi_bound = last_w + win_w;
    assign lim_w    = {1'b0, cfg.reject_limit};
    assign neg_lim  = -lim_w;
    assign go_low   = (s_w < lo_bound) && (run_reg > neg_lim);
    assign go_high  = !go_low && (s_w > hi_bound) && (run_reg < lim_w);

    always_comb begin
        last_next = last_reg;
        rej_next  = 1'b1;
        if (go_low) begin
            run_next = (run_reg > 8'sd0) ? 8'sd0 : run_reg - 8'sd1;
        end else if (go_high) begin
            run_next = (run_reg < 8'sd0) ? 8'sd0 : run_reg + 8'sd1;
        end else begin
            run_next  = 8'sd0;
            last_next = s1_sample_reg;
            rej_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            last_reg    <= '0;
            run_reg     <= '0;
        end else begin
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (fire) begin
                last_reg <= last_next;
                run_reg  <= run_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_value_reg <= last_next;
            m_rej_reg   <= rej_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(asrf_pkg::M_TDATA_W-asrf_pkg::SAMPLE_W){1'b0}}, m_value_reg};
    assign m_tuser  = m_rej_reg;

    a_out_matches_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_value_reg == last_reg))
        else $error("result word differs from stored last value");

    a_run_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg != 8'sh80)
        else $error("run counter left its range");

    a_accept_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_rej_reg) |-> (run_reg == 8'sd0))
        else $error("accepted word with nonzero run counter");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> ($stable(last_reg) && $stable(run_reg)))
        else $error("filter state moved while result stalled");

endmodule

`default_nettype wire
